[rtl/core/blpx_pkg.sv]
// ----------------------------------------------------------------------------
// blpx_pkg: shared types and constants of the line pixel stepper
// Register indexes, fixed field widths, the configuration bundle and the
// command word width shared by the front end, the queue and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package blpx_pkg;

    // Defaults for the top level parameters.
    localparam int COORD_BITS_DEF  = 13;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Fixed field widths.
    localparam int COLOR_W    = 32;
    localparam int OFFSET_W   = 28;
    localparam int DIM_W      = 12;
    localparam int PITCH_W    = 16;
    localparam int BPP_W      = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PX = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd3;

    localparam logic [BPP_W-1:0] BPP_RESET = 3'd4;

    // Action codes of an input beat.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    typedef struct packed {
        logic [PITCH_W-1:0] row_pitch;
        logic [BPP_W-1:0]   bytes_per_pixel;
        logic [DIM_W-1:0]   image_width;
        logic [DIM_W-1:0]   image_height;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Width of one queued command for a given coordinate width.
    function automatic int cmd_bits(input int coord_bits);
        return 6 * coord_bits + 42;
    endfunction

endpackage

`default_nettype wire

[rtl/core/blpx_fifo.sv]
// ----------------------------------------------------------------------------
// blpx_fifo: short command queue
// A small register queue between the front end and the back end, so that
// each side can stall without holding up the other.
// ----------------------------------------------------------------------------
`default_nettype none

module blpx_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         push,
    input  wire  [WIDTH-1:0]            push_data,
    input  wire                         pop,
    output logic [WIDTH-1:0]            pop_data,
    output blpx_pkg::q_status_t         status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_data     = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[rtl/core/blpx_front.sv]
// ----------------------------------------------------------------------------
// blpx_front: beat classification and line setup
// Turns a load beat into a ready-made command (ordered endpoints, major axis,
// doubled deltas, initial error, step count); a step beat passes as a step.
// ----------------------------------------------------------------------------
`default_nettype none

module blpx_front #(
    parameter int COORD_BITS = blpx_pkg::COORD_BITS_DEF,
    parameter int CMD_W      = blpx_pkg::cmd_bits(COORD_BITS)
) (
    input  wire                                 action,
    input  wire  signed [COORD_BITS-1:0]        x_first,
    input  wire  signed [COORD_BITS-1:0]        y_first,
    input  wire  signed [COORD_BITS-1:0]        x_second,
    input  wire  signed [COORD_BITS-1:0]        y_second,
    input  wire         [blpx_pkg::COLOR_W-1:0] color_first,
    input  wire         [blpx_pkg::COLOR_W-1:0] color_second,
    output logic        [CMD_W-1:0]             cmd_word
);

    localparam int C = COORD_BITS;

    typedef struct packed {
        logic                         action;
        logic [C-1:0]                 x0;
        logic [C-1:0]                 y0;
        logic [blpx_pkg::COLOR_W-1:0] color;
        logic [1:0]                   sense;
        logic                         x_major;
        logic [C:0]                   tmaj;
        logic [C:0]                   tmin;
        logic [C+2:0]                 err;
        logic [C:0]                   steps;
    } cmd_t;

    cmd_t         cmd;
    logic         swap;
    logic [C-1:0] xa, ya, xb, yb;
    logic [C:0]   dx, dy, adx, maj, mnr;

    always_comb begin
        // The first endpoint counts as the lower one when the y values tie.
        swap = (y_first > y_second);
        xa   = swap ? x_second : x_first;
        ya   = swap ? y_second : y_first;
        xb   = swap ? x_first  : x_second;
        yb   = swap ? y_first  : y_second;

        dx  = {xb[C-1], xb} - {xa[C-1], xa};
        dy  = {yb[C-1], yb} - {ya[C-1], ya};
        adx = dx[C] ? (~dx + 1'b1) : dx;

        cmd.action  = action;
        cmd.x0      = xa;
        cmd.y0      = ya;
        cmd.color   = swap ? color_second : color_first;
        cmd.sense   = dx[C] ? 2'b11 : ((dx != '0) ? 2'b01 : 2'b00);
        cmd.x_major = (adx > dy);
        maj         = cmd.x_major ? adx : dy;
        mnr         = cmd.x_major ? dy  : adx;
        cmd.tmaj    = {maj[C-1:0], 1'b0};
        cmd.tmin    = {mnr[C-1:0], 1'b0};
        cmd.err     = {1'b0, mnr, 1'b0} - {2'b00, maj};
        cmd.steps   = maj;
        cmd_word    = cmd;
    end

endmodule

`default_nettype wire

[rtl/core/blpx_back.sv]
// ----------------------------------------------------------------------------
// blpx_back: line walker and pixel address pipeline
// Holds the line state, advances one pixel per step command while steps remain,
// then checks bounds, forms the byte offset and puts out the result pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module blpx_back #(
    parameter int COORD_BITS = blpx_pkg::COORD_BITS_DEF,
    parameter int CMD_W      = blpx_pkg::cmd_bits(COORD_BITS)
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire  blpx_pkg::cfg_t                 cfg,
    input  wire         [CMD_W-1:0]              cmd_word,
    input  wire  blpx_pkg::q_status_t            q_status,
    output logic                                 cmd_pop,
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output logic signed [COORD_BITS-1:0]         m_pixel_x,
    output logic signed [COORD_BITS-1:0]         m_pixel_y,
    output logic        [blpx_pkg::OFFSET_W-1:0] m_byte_offset,
    output logic        [blpx_pkg::COLOR_W-1:0]  m_pixel_color,
    output logic                                 m_in_bounds,
    output logic                                 m_last
);

    localparam int C   = COORD_BITS;
    localparam int XW  = COORD_BITS + blpx_pkg::DIM_W;
    localparam int PYW = blpx_pkg::DIM_W + blpx_pkg::PITCH_W;
    localparam int PXW = blpx_pkg::DIM_W + blpx_pkg::BPP_W;

    typedef struct packed {
        logic                         action;
        logic [C-1:0]                 x0;
        logic [C-1:0]                 y0;
        logic [blpx_pkg::COLOR_W-1:0] color;
        logic [1:0]                   sense;
        logic                         x_major;
        logic [C:0]                   tmaj;
        logic [C:0]                   tmin;
        logic [C+2:0]                 err;
        logic [C:0]                   steps;
    } cmd_t;

    cmd_t cmd;
    logic adv;
    logic do_step;

    // Line state.
    logic [C-1:0]                 cur_x_reg, cur_x_next;
    logic [C-1:0]                 cur_y_reg, cur_y_next;
    logic [C+2:0]                 err_reg, err_next;
    logic [C:0]                   tmaj_reg, tmin_reg;
    logic [C:0]                   steps_reg, steps_next;
    logic [1:0]                   sense_reg;
    logic                         x_major_reg;
    logic [blpx_pkg::COLOR_W-1:0] color_reg;

    // Walk stage.
    logic                         p1_valid_reg;
    logic [C-1:0]                 p1_x_reg, p1_y_reg;
    logic [blpx_pkg::COLOR_W-1:0] p1_color_reg;
    logic                         p1_last_reg;

    // Product stage.
    logic                         p2_valid_reg;
    logic [C-1:0]                 p2_x_reg, p2_y_reg;
    logic [blpx_pkg::COLOR_W-1:0] p2_color_reg;
    logic                         p2_last_reg;
    logic                         p2_in_reg;
    logic [PYW-1:0]               p2_prod_y_reg;
    logic [PXW-1:0]               p2_prod_x_reg;

    logic                         err_ge0;
    logic [C-1:0]                 sense_ext;
    logic                         in_bounds;
    logic [blpx_pkg::DIM_W-1:0]   x_idx, y_idx;

    assign cmd     = cmd_t'(cmd_word);
    assign adv     = !m_valid || m_ready;
    assign cmd_pop = adv && !q_status.empty;
    assign do_step = cmd_pop && (cmd.action == blpx_pkg::ACT_STEP) && (steps_reg != '0);

    always_comb begin
        err_ge0    = !err_reg[C+2];
        sense_ext  = {{(C-2){sense_reg[1]}}, sense_reg};
        err_next   = err_reg + {2'b00, tmin_reg} - (err_ge0 ? {2'b00, tmaj_reg} : '0);
        steps_next = steps_reg - 1'b1;
        if (x_major_reg) begin
            cur_x_next = cur_x_reg + sense_ext;
            cur_y_next = err_ge0 ? cur_y_reg + 1'b1 : cur_y_reg;
        end else begin
            cur_x_next = err_ge0 ? cur_x_reg + sense_ext : cur_x_reg;
            cur_y_next = cur_y_reg + 1'b1;
        end
    end

    always_comb begin
        in_bounds = !p1_x_reg[C-1] && !p1_y_reg[C-1]
                 && (XW'(p1_x_reg) < XW'(cfg.image_width))
                 && (XW'(p1_y_reg) < XW'(cfg.image_height));
        x_idx = blpx_pkg::DIM_W'(p1_x_reg);
        y_idx = blpx_pkg::DIM_W'(p1_y_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg    <= '0;
            cur_y_reg    <= '0;
            err_reg      <= '0;
            tmaj_reg     <= '0;
            tmin_reg     <= '0;
            steps_reg    <= '0;
            sense_reg    <= '0;
            x_major_reg  <= 1'b0;
            color_reg    <= '0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            m_valid      <= 1'b0;
        end else if (adv) begin
            if (cmd_pop && (cmd.action == blpx_pkg::ACT_LOAD)) begin
                cur_x_reg   <= cmd.x0;
                cur_y_reg   <= cmd.y0;
                err_reg     <= cmd.err;
                tmaj_reg    <= cmd.tmaj;
                tmin_reg    <= cmd.tmin;
                steps_reg   <= cmd.steps;
                sense_reg   <= cmd.sense;
                x_major_reg <= cmd.x_major;
                color_reg   <= cmd.color;
            end else if (do_step) begin
                cur_x_reg <= cur_x_next;
                cur_y_reg <= cur_y_next;
                err_reg   <= err_next;
                steps_reg <= steps_next;
            end
            p1_valid_reg <= do_step;
            p2_valid_reg <= p1_valid_reg;
            m_valid      <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_x_reg      <= cur_x_next;
            p1_y_reg      <= cur_y_next;
            p1_color_reg  <= color_reg;
            p1_last_reg   <= (steps_next == '0);

            p2_x_reg      <= p1_x_reg;
            p2_y_reg      <= p1_y_reg;
            p2_color_reg  <= p1_color_reg;
            p2_last_reg   <= p1_last_reg;
            p2_in_reg     <= in_bounds;
            p2_prod_y_reg <= y_idx * cfg.row_pitch;
            p2_prod_x_reg <= x_idx * cfg.bytes_per_pixel;

            m_pixel_x     <= p2_x_reg;
            m_pixel_y     <= p2_y_reg;
            m_pixel_color <= p2_color_reg;
            m_last        <= p2_last_reg;
            m_in_bounds   <= p2_in_reg;
            m_byte_offset <= p2_in_reg
                ? blpx_pkg::OFFSET_W'(p2_prod_y_reg) + blpx_pkg::OFFSET_W'(p2_prod_x_reg)
                : '0;
        end
    end

endmodule

`default_nettype wire

[rtl/core/bresenham_line_pixel_stepper_core.sv]
// ----------------------------------------------------------------------------
// bresenham_line_pixel_stepper_core: line rasterizer pixel stepper
// Loads a line between two endpoints, walks it one pixel per step beat until its
// end, giving each pixel's coordinates, color, byte offset and in-bounds flag.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  s_*       in         s_valid / s_ready    action, endpoints, endpoint colors
//  m_*       out        m_valid / m_ready    pixel x/y, byte offset, color, flags
//  cfg_*     in         cfg_valid/cfg_ready  register index, write data
//
// The block takes one beat per cycle while the queue has room and gives one pixel per
// cycle while m_ready holds. A step beat passes through the command queue, the
// Bresenham walk register and the multiplier stage, then the offset sum lands in the
// output register. Reset clears the queue and the pipeline, leaves no line active and
// returns the registers to their reset values. A stall on m_ready freezes the back
// end; the queue fills and s_ready falls once it is full. Configuration writes are
// taken on every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bresenham_line_pixel_stepper_core #(
    parameter int COORD_BITS  = blpx_pkg::COORD_BITS_DEF,
    parameter int QUEUE_DEPTH = blpx_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                                    aclk,
    input  wire                                    aresetn,

    input  wire                                    s_valid,
    output logic                                   s_ready,
    input  wire                                    s_action,
    input  wire  signed [COORD_BITS-1:0]           s_x_first,
    input  wire  signed [COORD_BITS-1:0]           s_y_first,
    input  wire  signed [COORD_BITS-1:0]           s_x_second,
    input  wire  signed [COORD_BITS-1:0]           s_y_second,
    input  wire         [blpx_pkg::COLOR_W-1:0]    s_color_first,
    input  wire         [blpx_pkg::COLOR_W-1:0]    s_color_second,

    output logic                                   m_valid,
    input  wire                                    m_ready,
    output logic signed [COORD_BITS-1:0]           m_pixel_x,
    output logic signed [COORD_BITS-1:0]           m_pixel_y,
    output logic        [blpx_pkg::OFFSET_W-1:0]   m_byte_offset,
    output logic        [blpx_pkg::COLOR_W-1:0]    m_pixel_color,
    output logic                                   m_in_bounds,
    output logic                                   m_last,

    input  wire                                    cfg_valid,
    output logic                                   cfg_ready,
    input  wire         [blpx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire         [blpx_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int CMD_W = blpx_pkg::cmd_bits(COORD_BITS);

    blpx_pkg::cfg_t      cfg_reg;
    blpx_pkg::q_status_t q_status;
    logic [CMD_W-1:0]    front_cmd;
    logic [CMD_W-1:0]    queue_cmd;
    logic                q_push;
    logic                q_pop;

    // Register writes land at once; the user, not the block, keeps it idle when they come.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.row_pitch       <= '0;
            cfg_reg.bytes_per_pixel <= blpx_pkg::BPP_RESET;
            cfg_reg.image_width     <= '0;
            cfg_reg.image_height    <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                blpx_pkg::REG_ROW_PITCH: begin
                    cfg_reg.row_pitch <= cfg_data[blpx_pkg::PITCH_W-1:0];
                end
                blpx_pkg::REG_BYTES_PER_PX: begin
                    cfg_reg.bytes_per_pixel <= cfg_data[blpx_pkg::BPP_W-1:0];
                end
                blpx_pkg::REG_IMAGE_WIDTH: begin
                    cfg_reg.image_width <= cfg_data[blpx_pkg::DIM_W-1:0];
                end
                blpx_pkg::REG_IMAGE_HEIGHT: begin
                    cfg_reg.image_height <= cfg_data[blpx_pkg::DIM_W-1:0];
                end
                default: begin
                    // Writes beyond the register list are dropped.
                end
            endcase
        end
    end

    // The front end accepts a beat whenever the queue has room.
    assign s_ready = !q_status.full;
    assign q_push  = s_valid && s_ready;

    blpx_front #(
        .COORD_BITS (COORD_BITS),
        .CMD_W      (CMD_W)
    ) u_front (
        .action       (s_action),
        .x_first      (s_x_first),
        .y_first      (s_y_first),
        .x_second     (s_x_second),
        .y_second     (s_y_second),
        .color_first  (s_color_first),
        .color_second (s_color_second),
        .cmd_word     (front_cmd)
    );

    blpx_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (front_cmd),
        .pop       (q_pop),
        .pop_data  (queue_cmd),
        .status    (q_status)
    );

    // The back end pulls one command per cycle unless its output is stalled or the queue is empty.
    blpx_back #(
        .COORD_BITS (COORD_BITS),
        .CMD_W      (CMD_W)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .cmd_word      (queue_cmd),
        .q_status      (q_status),
        .cmd_pop       (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_byte_offset (m_byte_offset),
        .m_pixel_color (m_pixel_color),
        .m_in_bounds   (m_in_bounds),
        .m_last        (m_last)
    );

`ifndef SYNTHESIS
    // The back end never takes a command from an empty queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_status.empty)
        else $error("command popped from empty queue");

    // A pixel outside the image carries a zero offset.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_in_bounds) |-> (m_byte_offset == '0))
        else $error("out of bounds pixel with nonzero offset");

    // A pixel marked inside the image has nonnegative coordinates.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_in_bounds) |->
            (!m_pixel_x[COORD_BITS-1] && !m_pixel_y[COORD_BITS-1]))
        else $error("in bounds pixel with negative coordinate");

    // A stalled result beat keeps its last flag and byte offset while the back end is frozen.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_last) && $stable(m_byte_offset))
        else $error("stalled pixel changed");
`endif

endmodule

`default_nettype wire
